// ===== design/brs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// Shared widths, codes and controller/datapath interface types for the
// block request splitter.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned OFF_W     = 48;  // byte offset
  localparam int unsigned LEN_W     = 28;  // byte length, buffer offsets
  localparam int unsigned BS_W      = 17;  // block size
  localparam int unsigned BCNT_W    = 33;  // block count
  localparam int unsigned LBA_W     = 32;  // command LBA
  localparam int unsigned NUM_W     = 16;  // blocks per command, partial fields
  localparam int unsigned CFG_W     = 33;  // widest register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIVD_W    = OFF_W + 1;  // offset + length
  // blocks left at a clamped end: span * 512 - 511 < 2**LEN_W
  localparam int unsigned SPAN_W    = LEN_W - 9 + 1;

  localparam int unsigned MAX_RESULTS = 11;
  localparam int unsigned RCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [BS_W-1:0] MIN_BLOCK = 17'd512;
  localparam logic [BS_W-1:0] MAX_BLOCK = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_ONLINE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_PART_READ,
    KIND_PART_RMW,
    KIND_NONE
  } brs_kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_ERROR
  } brs_status_t;

  // which result the datapath forms
  typedef enum logic [2:0] {
    SEL_BAD,
    SEL_NONE,
    SEL_HEAD,
    SEL_RUN,
    SEL_TAIL
  } brs_sel_t;

  typedef struct packed {
    logic     load_req;
    logic     start_div;
    logic     clamp;
    logic     mul;
    logic     setup;
    logic     run_prep;
    logic     run_mul;
    logic     emit;
    brs_sel_t sel;
  } brs_cmd_t;

  typedef struct packed {
    logic bad_cfg;
    logic div_busy;
    logic nothing;
    logic head;
    logic body_left;
    logic out_free;
    logic emit_last;
  } brs_stat_t;

endpackage
`default_nettype wire

// ===== design/brs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_div
// Restoring divider, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module brs_div #(
  parameter int unsigned DIVIDEND_W = 49,
  parameter int unsigned DIVISOR_W  = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic [DIVISOR_W-1:0]       remainder
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W);

  logic [STEP_W-1:0]    step;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   trial_sub;
  logic                 fits;

  assign trial     = {remainder, quotient[DIVIDEND_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign trial_sub = fits ? (trial - {1'b0, dvs}) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIVIDEND_W-2:0], fits};
      remainder <= trial_sub[DIVISOR_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/brs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_dp
// Datapath: configuration registers, request capture, two dividers, clamp,
// command formation and the output register.
// ----------------------------------------------------------------------------
module brs_dp #(
  parameter int unsigned MAX_BLOCKS_PER_COMMAND = 65535
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [brs_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              is_write,
  input  wire logic [brs_pkg::OFF_W-1:0]         byte_offset,
  input  wire logic [brs_pkg::LEN_W-1:0]         byte_length,
  input  wire brs_pkg::brs_cmd_t                 cmd,
  output brs_pkg::brs_stat_t                     stat,
  input  wire logic                              cmd_stall,
  output logic                                   cmd_valid,
  output logic [2:0]                             kind,
  output logic [brs_pkg::LBA_W-1:0]              lba,
  output logic [brs_pkg::NUM_W-1:0]              block_num,
  output logic [brs_pkg::LEN_W-1:0]              buffer_offset,
  output logic [brs_pkg::NUM_W-1:0]              part_offset,
  output logic [brs_pkg::NUM_W-1:0]              part_length,
  output logic [1:0]                             status,
  output logic [brs_pkg::LEN_W-1:0]              returned_bytes,
  output logic                                   last
);

  localparam int unsigned DW = brs_pkg::DIVD_W;
  localparam int unsigned NW = brs_pkg::NUM_W;
  localparam int unsigned LW = brs_pkg::LEN_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_BLOCKS_PER_COMMAND);

  // configuration
  logic                        online;
  logic [brs_pkg::BS_W-1:0]    bs;
  logic [brs_pkg::BCNT_W-1:0]  bcount;

  // request
  logic                        wr;
  logic [brs_pkg::OFF_W-1:0]   off;
  logic [LW-1:0]               len;

  // dividers
  logic                        busy_s;
  logic                        busy_e;
  logic [DW-1:0]               qs;
  logic [brs_pkg::BS_W-1:0]    rs;
  logic [DW-1:0]               qe_raw;
  logic [brs_pkg::BS_W-1:0]    re_raw;
  logic [DW-1:0]               end_pos;

  // clamp and setup
  logic                        nothing;
  logic                        clamped;
  logic                        clamp_hit;
  logic [DW-1:0]               count_ext;
  logic [DW-1:0]               qe;
  logic [brs_pkg::BS_W-1:0]    re;
  logic [brs_pkg::BCNT_W-1:0]  span_full;
  logic [brs_pkg::SPAN_W-1:0]  span;
  logic [brs_pkg::SPAN_W+brs_pkg::BS_W-1:0] prod;
  logic [LW-1:0]               ret_len;
  logic                        head_after;
  logic [NW-1:0]               head_len;

  // walk
  logic [DW-1:0]               cur_lba;
  logic [LW-1:0]               pos;
  logic [brs_pkg::RCNT_W-1:0]  rcnt;
  logic [DW-1:0]               blk_left;
  logic [NW-1:0]               n_next;
  logic [NW-1:0]               n_r;
  logic                        run_after;
  logic [NW+brs_pkg::BS_W-1:0] chunk_full;
  logic [LW-1:0]               chunk;

  // result formation
  logic                        is_cmd;
  logic                        fail;
  logic                        e_after;
  brs_pkg::brs_kind_t          e_kind;
  brs_pkg::brs_status_t        e_status;
  logic [NW-1:0]               e_num;
  logic [NW-1:0]               e_poff;
  logic [NW-1:0]               e_plen;
  brs_pkg::brs_kind_t          r_kind;
  brs_pkg::brs_status_t        r_status;
  logic [brs_pkg::LBA_W-1:0]   r_lba;
  logic [NW-1:0]               r_num;
  logic [LW-1:0]               r_buf;
  logic [NW-1:0]               r_poff;
  logic [NW-1:0]               r_plen;
  logic [LW-1:0]               r_ret;
  logic                        r_last;
  logic                        out_free;
  logic                        emit_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      online <= 1'b0;
      bs     <= brs_pkg::MIN_BLOCK;
      bcount <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brs_pkg::REG_ONLINE:      online <= cfg_data[0];
        brs_pkg::REG_BLOCK_SIZE:  bs     <= cfg_data[brs_pkg::BS_W-1:0];
        brs_pkg::REG_BLOCK_COUNT: bcount <= cfg_data;
        default: ;
      endcase
    end
  end

  assign end_pos = {1'b0, off} + DW'(len);

  brs_div #(.DIVIDEND_W(DW), .DIVISOR_W(brs_pkg::BS_W)) u_div_start (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_div),
    .dividend  ({1'b0, off}),
    .divisor   (bs),
    .busy      (busy_s),
    .quotient  (qs),
    .remainder (rs)
  );

  brs_div #(.DIVIDEND_W(DW), .DIVISOR_W(brs_pkg::BS_W)) u_div_end (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_div),
    .dividend  (end_pos),
    .divisor   (bs),
    .busy      (busy_e),
    .quotient  (qe_raw),
    .remainder (re_raw)
  );

  assign count_ext = DW'(bcount);
  assign clamp_hit = (qe_raw > count_ext) || ((qe_raw == count_ext) && (re_raw != '0));
  assign span_full = bcount - qs[brs_pkg::BCNT_W-1:0];

  assign blk_left   = qe - cur_lba;
  assign n_next     = (blk_left > DW'(MAX_N)) ? MAX_N : blk_left[NW-1:0];
  assign chunk_full = n_r * bs;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      wr  <= is_write;
      off <= byte_offset;
      len <= byte_length;
    end
    if (cmd.clamp) begin
      nothing <= (qs >= count_ext) || (len == '0);
      clamped <= clamp_hit;
      qe      <= clamp_hit ? count_ext : qe_raw;
      re      <= clamp_hit ? '0 : re_raw;
      span    <= span_full[brs_pkg::SPAN_W-1:0];
    end
    if (cmd.mul) begin
      prod <= span * bs;
    end
    if (cmd.setup) begin
      ret_len    <= clamped ? (prod[LW-1:0] - LW'(rs)) : len;
      head_after <= (qe != qs) && ((qe != (qs + DW'(1))) || (re != '0));
      head_len   <= (qe == qs) ? NW'(re - rs) : NW'(bs - rs);
      cur_lba    <= qs;
      pos        <= '0;
      rcnt       <= '0;
    end
    if (cmd.run_prep) begin
      n_r       <= n_next;
      run_after <= (blk_left != DW'(n_next)) || (re != '0);
    end
    if (cmd.run_mul) begin
      chunk <= chunk_full[LW-1:0];
    end
    if (emit_fire) begin
      rcnt <= rcnt + 1'b1;
      if (!r_last && (cmd.sel == brs_pkg::SEL_HEAD)) begin
        pos     <= pos + LW'(head_len);
        cur_lba <= cur_lba + DW'(1);
      end else if (!r_last && (cmd.sel == brs_pkg::SEL_RUN)) begin
        pos     <= pos + chunk;
        cur_lba <= cur_lba + DW'(n_r);
      end
    end
  end

  always_comb begin
    is_cmd   = 1'b0;
    e_after  = 1'b0;
    e_kind   = brs_pkg::KIND_NONE;
    e_status = brs_pkg::ST_OK;
    e_num    = '0;
    e_poff   = '0;
    e_plen   = '0;
    unique case (cmd.sel)
      brs_pkg::SEL_BAD: begin
        e_status = brs_pkg::ST_ERROR;
      end
      brs_pkg::SEL_NONE: begin
        e_status = brs_pkg::ST_EMPTY;
      end
      brs_pkg::SEL_HEAD: begin
        is_cmd  = 1'b1;
        e_kind  = wr ? brs_pkg::KIND_PART_RMW : brs_pkg::KIND_PART_READ;
        e_num   = NW'(1);
        e_poff  = rs[NW-1:0];
        e_plen  = head_len;
        e_after = head_after;
      end
      brs_pkg::SEL_RUN: begin
        is_cmd  = 1'b1;
        e_kind  = wr ? brs_pkg::KIND_WRITE : brs_pkg::KIND_READ;
        e_num   = n_r;
        e_after = run_after;
      end
      brs_pkg::SEL_TAIL: begin
        is_cmd  = 1'b1;
        e_kind  = wr ? brs_pkg::KIND_PART_RMW : brs_pkg::KIND_PART_READ;
        e_num   = NW'(1);
        e_plen  = re[NW-1:0];
      end
      default: ;
    endcase

    // address past 32 bits, or out of result slots while more remains
    fail = is_cmd && ((cur_lba[DW-1:brs_pkg::LBA_W] != '0) ||
                      ((rcnt >= brs_pkg::RCNT_W'(brs_pkg::MAX_RESULTS - 1)) && e_after));

    r_kind   = brs_pkg::KIND_NONE;
    r_status = e_status;
    r_lba    = '0;
    r_num    = '0;
    r_buf    = '0;
    r_poff   = '0;
    r_plen   = '0;
    r_ret    = '0;
    r_last   = 1'b1;
    if (fail) begin
      r_status = brs_pkg::ST_ERROR;
    end else if (is_cmd) begin
      r_kind = e_kind;
      r_lba  = cur_lba[brs_pkg::LBA_W-1:0];
      r_num  = e_num;
      r_buf  = pos;
      r_poff = e_poff;
      r_plen = e_plen;
      r_ret  = e_after ? '0 : ret_len;
      r_last = !e_after;
    end
  end

  assign out_free  = !cmd_valid || !cmd_stall;
  assign emit_fire = cmd.emit && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (emit_fire) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      kind           <= r_kind;
      lba            <= r_lba;
      block_num      <= r_num;
      buffer_offset  <= r_buf;
      part_offset    <= r_poff;
      part_length    <= r_plen;
      status         <= r_status;
      returned_bytes <= r_ret;
      last           <= r_last;
    end
  end

  assign stat.bad_cfg   = !online || (bcount == '0) || (bs < brs_pkg::MIN_BLOCK) ||
                          (bs > brs_pkg::MAX_BLOCK);
  assign stat.div_busy  = busy_s || busy_e;
  assign stat.nothing   = nothing;
  // an unaligned start needs a head bounce command
  assign stat.head      = (rs != '0);
  assign stat.body_left = (qe != cur_lba);
  assign stat.out_free  = out_free;
  assign stat.emit_last = r_last;

endmodule
`default_nettype wire

// ===== design/brs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_ctrl
// Controller: sequences capture, configuration check, divide, clamp, multiply, setup and command emission.
// ----------------------------------------------------------------------------
module brs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  output brs_pkg::brs_cmd_t       cmd,
  input  wire brs_pkg::brs_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_CLAMP,
    S_MUL,
    S_SETUP,
    S_NEXT,
    S_RUN_PREP,
    S_RUN_MUL,
    S_EMIT_BAD,
    S_EMIT_NONE,
    S_EMIT_HEAD,
    S_EMIT_RUN,
    S_EMIT_TAIL
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.sel    = brs_pkg::SEL_BAD;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad_cfg) begin
          state_next = S_EMIT_BAD;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        priority if (stat.nothing) begin
          state_next = S_EMIT_NONE;
        end else if (stat.head) begin
          state_next = S_EMIT_HEAD;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        state_next = stat.body_left ? S_RUN_PREP : S_EMIT_TAIL;
      end
      S_RUN_PREP: begin
        cmd.run_prep = 1'b1;
        state_next   = S_RUN_MUL;
      end
      S_RUN_MUL: begin
        cmd.run_mul = 1'b1;
        state_next  = S_EMIT_RUN;
      end
      S_EMIT_BAD, S_EMIT_NONE, S_EMIT_TAIL: begin
        cmd.emit = 1'b1;
        unique case (state)
          S_EMIT_NONE: cmd.sel = brs_pkg::SEL_NONE;
          S_EMIT_TAIL: cmd.sel = brs_pkg::SEL_TAIL;
          default:     cmd.sel = brs_pkg::SEL_BAD;
        endcase
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_HEAD, S_EMIT_RUN: begin
        cmd.emit = 1'b1;
        cmd.sel  = (state == S_EMIT_HEAD) ? brs_pkg::SEL_HEAD : brs_pkg::SEL_RUN;
        if (stat.out_free) begin
          state_next = stat.emit_last ? S_IDLE : S_NEXT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/block_request_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_request_splitter
// Splits a byte-range read or write request into block commands.
// ----------------------------------------------------------------------------
// One request is taken at a time; the next is accepted as soon as the last
// result of the current one has been loaded into the output register, even if
// that result is still stalled. A request is captured and checked, then two
// 49-bit restoring dividers (start and end byte divided by the block size, run
// side by side) run, then clamp, multiply and setup come before its first result.
// Each partial command then needs only its emit step, each run of whole blocks
// its block count, byte multiply and emit steps, plus a decision step between
// commands, all extended by any stall on the command channel. On an unusable
// disk an error follows the check. Results come out in order; the final one
// carries last, status and clamped length. Registers are written on the cfg
// port by the user only with no request in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module block_request_splitter #(
  parameter int unsigned MAX_BLOCKS_PER_COMMAND = 65535
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // register writes
  input  wire logic                          cfg_we,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brs_pkg::CFG_W-1:0]     cfg_data,
  // request transaction
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          is_write,
  input  wire logic [brs_pkg::OFF_W-1:0]     byte_offset,
  input  wire logic [brs_pkg::LEN_W-1:0]     byte_length,
  // command transaction
  output logic                               cmd_valid,
  input  wire logic                          cmd_stall,
  output logic [2:0]                         kind,
  output logic [brs_pkg::LBA_W-1:0]          lba,
  output logic [brs_pkg::NUM_W-1:0]          block_num,
  output logic [brs_pkg::LEN_W-1:0]          buffer_offset,
  output logic [brs_pkg::NUM_W-1:0]          part_offset,
  output logic [brs_pkg::NUM_W-1:0]          part_length,
  output logic [1:0]                         status,
  output logic [brs_pkg::LEN_W-1:0]          returned_bytes,
  output logic                               last
);

  brs_pkg::brs_cmd_t  cmd;
  brs_pkg::brs_stat_t stat;

  // Sequence the request: capture, divide, clamp, then walk head/runs/tail.
  brs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold registers, dividers, the walk position and the output register.
  brs_dp #(
    .MAX_BLOCKS_PER_COMMAND (MAX_BLOCKS_PER_COMMAND)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .is_write       (is_write),
    .byte_offset    (byte_offset),
    .byte_length    (byte_length),
    .cmd            (cmd),
    .stat           (stat),
    .cmd_stall      (cmd_stall),
    .cmd_valid      (cmd_valid),
    .kind           (kind),
    .lba            (lba),
    .block_num      (block_num),
    .buffer_offset  (buffer_offset),
    .part_offset    (part_offset),
    .part_length    (part_length),
    .status         (status),
    .returned_bytes (returned_bytes),
    .last           (last)
  );

endmodule
`default_nettype wire

// ===== design/brs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_props
// Port-level checks on the command channel of the block request splitter.
// ----------------------------------------------------------------------------
module brs_props (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         cmd_valid,
  input wire logic                         cmd_stall,
  input wire logic [2:0]                   kind,
  input wire logic [brs_pkg::LBA_W-1:0]    lba,
  input wire logic [brs_pkg::NUM_W-1:0]    block_num,
  input wire logic [1:0]                   status,
  input wire logic [brs_pkg::LEN_W-1:0]    returned_bytes,
  input wire logic                         last
);

  // hold a stalled transaction
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(kind) && $stable(lba) &&
                               $stable(status) && $stable(last))
    else $error("stalled command transaction changed");

  // any non-ok status ends the request with no command
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (status != brs_pkg::ST_OK) |-> (kind == brs_pkg::KIND_NONE) && last)
    else $error("non-ok status on a command or non-final result");

  // only the final result reports status and length
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !last |-> (status == brs_pkg::ST_OK) && (returned_bytes == '0))
    else $error("status or length reported before the final result");

  // partial commands cover exactly one block
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && ((kind == brs_pkg::KIND_PART_READ) || (kind == brs_pkg::KIND_PART_RMW))
      |-> (block_num == brs_pkg::NUM_W'(1)))
    else $error("partial command with block count other than one");

endmodule

bind block_request_splitter brs_props u_brs_props (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd_valid),
  .cmd_stall      (cmd_stall),
  .kind           (kind),
  .lba            (lba),
  .block_num      (block_num),
  .status         (status),
  .returned_bytes (returned_bytes),
  .last           (last)
);
`default_nettype wire
